// ===== design/quote_imbalance_signal_window_assert.svh =====
// Assertion macros for the quote imbalance signal window.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef QUOTE_IMBALANCE_SIGNAL_WINDOW_ASSERT_SVH
`define QUOTE_IMBALANCE_SIGNAL_WINDOW_ASSERT_SVH

// Same-cycle implication
`define QISW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qisw: same-cycle check failed");

// Next-cycle implication
`define QISW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qisw: next-cycle check failed");

`endif

// ===== design/qisw_pkg.sv =====
// Shared constants for the quote imbalance signal window.
// No dependencies.
package qisw_pkg;
  localparam int COUNT_BITS_DEF = 20;
  localparam int OUT_COUNT_W    = 20;

  localparam logic [1:0] SIG_NEUTRAL = 2'd0;
  localparam logic [1:0] SIG_BUY     = 2'd1;
  localparam logic [1:0] SIG_SELL    = 2'd2;
  localparam logic [1:0] SIG_UNUSED  = 2'd3;

  localparam logic [1:0] CFG_BUY_RATIO  = 2'd0;
  localparam logic [1:0] CFG_SELL_RATIO = 2'd1;
  localparam logic [1:0] CFG_MIN_TICK   = 2'd2;
  localparam logic [1:0] CFG_TICK_FRAC  = 2'd3;
endpackage

// ===== design/qisw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; the quotient must fit QW bits (dividend >> QW below divisor).
module qisw_div #(
  parameter int DW = 65,
  parameter int VW = 33,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient,
  output logic [VW-1:0] remainder
);
  localparam int CW = $clog2(QW + 1);

  logic [VW-1:0] rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic [VW:0]   cat;
  logic [VW:0]   diff;
  logic [VW:0]   top_ext;

  // Bring down the next dividend bit and trial-subtract
  assign cat  = {rem, low[QW-1]};
  assign diff = cat - {1'b0, divisor};
  assign top_ext = (VW+1)'(dividend[DW-1:QW]);

  // Load, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= top_ext[VW-1:0];
      low <= dividend[QW-1:0];
    end else if (busy) begin
      if (!diff[VW]) begin
        rem <= diff[VW-1:0];
        low <= {low[QW-2:0], 1'b1};
      end else begin
        rem <= cat[VW-1:0];
        low <= {low[QW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = low;
  assign remainder = rem;
endmodule

// ===== design/quote_imbalance_signal_window.sv =====
// Quote imbalance signal window: top level.
// A quote passes through the multiply, load and divide steps and then the result register;
// a close skips the multiply step.
// One item at a time; the next item is accepted the cycle after the result register
// loads, and the result register waits while out_stall holds a pending out_valid.
// Reset (rst, synchronous) clears window counts and history and restores default thresholds.
`include "quote_imbalance_signal_window_assert.svh"
module quote_imbalance_signal_window
  import qisw_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [30:0] bid,
  input  logic [30:0] ask,
  input  logic [31:0] bid_size,
  input  logic [31:0] ask_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  signal,
  output logic signed [31:0] spread,
  output logic [31:0] mid_doubled,
  output logic [31:0] weighted_mid_doubled,
  output logic [16:0] bid_share,
  output logic [OUT_COUNT_W-1:0] buy_total,
  output logic [OUT_COUNT_W-1:0] sell_total,
  output logic [OUT_COUNT_W-1:0] neutral_total,
  output logic [OUT_COUNT_W-1:0] quote_total,
  output logic signed [31:0] average_spread,
  output logic [31:0] last_mid_doubled
);
  localparam int ACC_W = 32 + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state;

  // Thresholds
  logic [15:0] buy_ratio, sell_ratio, tick_frac;
  logic [30:0] min_tick;

  // Window state
  logic [31:0] previous_mid, recent_mid;
  logic        previous_valid;
  logic [COUNT_BITS-1:0] buy_counter, sell_counter, neutral_counter, quote_counter;
  logic [COUNT_BITS-1:0] buy_next, sell_next, neutral_next;
  logic signed [ACC_W-1:0] spread_accumulator;

  // Item working registers
  logic        mode_r, pv_r, vol_gt, vol_lt;
  logic [30:0] bid_r, ask_r;
  logic [31:0] bv_r, bv_sh, av_sh, mid_r;
  logic [32:0] total_r;
  logic signed [31:0] spread_r;
  logic signed [33:0] diff2_r;
  logic signed [48:0] scaled_r;
  logic [63:0] num;
  logic [4:0]  mcnt;

  logic accept, finish, div_start, any_busy;
  logic [31:0] mid_in;
  logic signed [31:0] spread_in;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign mid_in    = {1'b0, bid} + {1'b0, ask};
  assign spread_in = signed'({1'b0, ask}) - signed'({1'b0, bid});
  assign div_start = (state == ST_LOAD);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buy_ratio  <= 16'd39322;
      sell_ratio <= 16'd26214;
      min_tick   <= 31'd1;
      tick_frac  <= 16'd16384;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BUY_RATIO:  buy_ratio  <= cfg_data[15:0];
        CFG_SELL_RATIO: sell_ratio <= cfg_data[15:0];
        CFG_MIN_TICK:   min_tick   <= cfg_data;
        CFG_TICK_FRAC:  tick_frac  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Dividers: weighted mid, bid share, average spread
  logic [31:0] wq, aq;
  logic [32:0] wr, sr_unused, sr;
  logic [16:0] sq;
  logic [COUNT_BITS-1:0] ar;
  logic w_busy, s_busy, a_busy;
  logic [ACC_W-1:0] acc_mag;
  logic acc_neg;

  assign acc_neg = spread_accumulator[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-spread_accumulator) : ACC_W'(spread_accumulator);

  qisw_div #(.DW(65), .VW(33), .QW(32)) u_wmid (
    .clk(clk), .rst(rst), .start(div_start), .dividend({num, 1'b0}),
    .divisor(total_r), .busy(w_busy), .quotient(wq), .remainder(wr));

  qisw_div #(.DW(48), .VW(33), .QW(17)) u_share (
    .clk(clk), .rst(rst), .start(div_start), .dividend({bv_r, 16'd0}),
    .divisor(total_r), .busy(s_busy), .quotient(sq), .remainder(sr));

  qisw_div #(.DW(ACC_W), .VW(COUNT_BITS), .QW(32)) u_avg (
    .clk(clk), .rst(rst), .start(div_start), .dividend(acc_mag),
    .divisor(quote_counter), .busy(a_busy), .quotient(aq), .remainder(ar));

  assign sr_unused = wr ^ sr;
  assign any_busy = w_busy || s_busy || a_busy || (ar != ar) || (sr_unused != sr_unused);
  assign finish   = (state == ST_DIV) && !any_busy && (!out_valid || !out_stall);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          state <= mode ? ST_LOAD : ST_MUL;
          mcnt  <= '0;
        end
        ST_MUL: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == 5'd31) state <= ST_LOAD;
        end
        ST_LOAD: state <= ST_DIV;
        ST_DIV: if (finish) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture the item; shift-add the cross products one volume bit per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode;
      bid_r    <= bid;
      ask_r    <= ask;
      bv_r     <= bid_size;
      bv_sh    <= bid_size;
      av_sh    <= ask_size;
      vol_gt   <= bid_size > ask_size;
      vol_lt   <= bid_size < ask_size;
      total_r  <= {1'b0, bid_size} + {1'b0, ask_size};
      mid_r    <= mid_in;
      spread_r <= spread_in;
      diff2_r  <= signed'({2'b0, mid_in}) - signed'({2'b0, previous_mid});
      pv_r     <= previous_valid;
      num      <= '0;
    end else if (state == ST_MUL) begin
      num <= (num << 1)
           + (bv_sh[31] ? {33'd0, ask_r} : 64'd0)
           + (av_sh[31] ? {33'd0, bid_r} : 64'd0);
      bv_sh <= bv_sh << 1;
      av_sh <= av_sh << 1;
      scaled_r <= 49'(spread_r * signed'({1'b0, tick_frac}));
    end
  end

  // Decide the quote signal
  logic [1:0] q_sig, c_sig, sig_final;
  logic dir_pos, dir_neg, share_above, share_below;
  logic signed [48:0] lhs, lhs_neg;
  logic signed [33:0] mt2, diff_neg;

  assign dir_pos     = (vol_gt && spread_r > 0) || (vol_lt && spread_r < 0);
  assign dir_neg     = (vol_lt && spread_r > 0) || (vol_gt && spread_r < 0);
  assign share_above = (sq > {1'b0, buy_ratio}) || (sq == {1'b0, buy_ratio} && sr != '0);
  assign share_below = sq < {1'b0, sell_ratio};
  assign lhs         = {diff2_r, 15'd0};
  assign lhs_neg     = -lhs;
  assign diff_neg    = -diff2_r;
  assign mt2         = signed'({2'b0, min_tick, 1'b0});

  always_comb begin
    q_sig = SIG_NEUTRAL;
    if (total_r != '0) begin
      if (dir_pos && share_above) q_sig = SIG_BUY;
      else if (dir_neg && share_below) q_sig = SIG_SELL;
    end else if (pv_r) begin
      if (diff2_r > mt2 && lhs > scaled_r) q_sig = SIG_BUY;
      else if (diff_neg > mt2 && lhs_neg > scaled_r) q_sig = SIG_SELL;
    end
  end

  // Majority on close: buy wins ties, then neutral
  always_comb begin
    if (buy_counter != '0 && buy_counter >= sell_counter && buy_counter >= neutral_counter)
      c_sig = SIG_BUY;
    else if (neutral_counter >= sell_counter)
      c_sig = SIG_NEUTRAL;
    else
      c_sig = SIG_SELL;
  end

  assign sig_final = mode_r ? c_sig : q_sig;

  always_comb begin
    buy_next     = buy_counter;
    sell_next    = sell_counter;
    neutral_next = neutral_counter;
    if (!mode_r) begin
      unique case (q_sig)
        SIG_BUY:  if (buy_counter != CNT_MAX) buy_next = buy_counter + 1'b1;
        SIG_SELL: if (sell_counter != CNT_MAX) sell_next = sell_counter + 1'b1;
        default:  if (neutral_counter != CNT_MAX) neutral_next = neutral_counter + 1'b1;
      endcase
    end
  end

  // Window state: quote accept moves count, sum, history; finish tallies or clears
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mid       <= '0;
      previous_valid     <= 1'b0;
      recent_mid         <= '0;
      buy_counter        <= '0;
      sell_counter       <= '0;
      neutral_counter    <= '0;
      quote_counter      <= '0;
      spread_accumulator <= '0;
    end else if (accept && !mode) begin
      previous_mid   <= mid_in;
      previous_valid <= 1'b1;
      recent_mid     <= mid_in;
      if (quote_counter != CNT_MAX) begin
        quote_counter      <= quote_counter + 1'b1;
        spread_accumulator <= spread_accumulator + ACC_W'(spread_in);
      end
    end else if (finish) begin
      if (mode_r) begin
        buy_counter        <= '0;
        sell_counter       <= '0;
        neutral_counter    <= '0;
        quote_counter      <= '0;
        spread_accumulator <= '0;
      end else begin
        buy_counter     <= buy_next;
        sell_counter    <= sell_next;
        neutral_counter <= neutral_next;
      end
    end
  end

  // Result register
  logic [COUNT_BITS+OUT_COUNT_W-1:0] b_ext, s_ext, n_ext, q_ext;
  assign b_ext = {{OUT_COUNT_W{1'b0}}, buy_next};
  assign s_ext = {{OUT_COUNT_W{1'b0}}, sell_next};
  assign n_ext = {{OUT_COUNT_W{1'b0}}, neutral_next};
  assign q_ext = {{OUT_COUNT_W{1'b0}}, quote_counter};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      signal               <= sig_final;
      spread               <= mode_r ? 32'sd0 : spread_r;
      mid_doubled          <= mode_r ? 32'd0 : mid_r;
      weighted_mid_doubled <= mode_r ? 32'd0 : ((total_r != '0) ? wq : mid_r);
      bid_share            <= (mode_r || total_r == '0) ? 17'd0 : sq;
      buy_total            <= b_ext[OUT_COUNT_W-1:0];
      sell_total           <= s_ext[OUT_COUNT_W-1:0];
      neutral_total        <= n_ext[OUT_COUNT_W-1:0];
      quote_total          <= q_ext[OUT_COUNT_W-1:0];
      average_spread       <= (quote_counter == '0) ? 32'sd0 :
                              (acc_neg ? -signed'(aq) : signed'(aq));
      last_mid_doubled     <= recent_mid;
    end
  end

  `QISW_ASSERT_NEXT(a_accept_starts, accept, (state == ST_MUL || state == ST_LOAD))
  `QISW_ASSERT_IMP(a_signal_code, out_valid, signal != SIG_UNUSED)
  `QISW_ASSERT_IMP(a_result_from_div, $rose(out_valid), $past(state == ST_DIV))
endmodule

// ===== test/quote_imbalance_signal_window_tb.sv =====
// Testbench for the quote imbalance signal window: drives quotes and closes,
// predicts each result in place and checks it field by field. Depends on qisw_pkg.
`timescale 1ns / 100ps
`default_nettype none
module quote_imbalance_signal_window_tb;
  import qisw_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = CFG_BUY_RATIO;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic mode = 0;
  logic [30:0] bid = '0, ask = '0;
  logic [31:0] bid_size = '0, ask_size = '0;
  logic out_valid, out_stall = 0;
  logic [1:0] signal;
  logic signed [31:0] spread, average_spread;
  logic [31:0] mid_doubled, weighted_mid_doubled, last_mid_doubled;
  logic [16:0] bid_share;
  logic [19:0] buy_total, sell_total, neutral_total, quote_total;

  quote_imbalance_signal_window dut (.*);

  typedef struct packed {
    logic [1:0] sig; logic [31:0] spr, mid2, wmid2; logic [16:0] share;
    logic [19:0] nb, ns, nn, nq; logic [31:0] avg, last;
  } quote_result_t;

  quote_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  // Thresholds and window state mirrored from the block
  logic [15:0] buy_thr, sell_thr, frac_thr;
  logic [30:0] tick_min;
  logic [32:0] prev_mid2, win_last_mid;
  logic prev_seen;
  logic [19:0] win_buy, win_sell, win_neutral, win_quotes;
  longint win_spread_sum;
  localparam logic [19:0] CNT_MAX = 20'hFFFFF;

  initial forever #4 clk = ~clk;

  function automatic logic [19:0] sat_inc(logic [19:0] c);
    return (c == CNT_MAX) ? c : c + 20'd1;
  endfunction

  // Compute the expected result of one transaction and advance the window
  function automatic quote_result_t predict_quote(logic m, logic [30:0] b, logic [30:0] a,
                                                  logic [31:0] bv, logic [31:0] av);
    quote_result_t r;
    logic [1:0] s;
    longint sp, d2, lhs, scaled, mt2;
    logic [63:0] tot, num, q, rem, bvs;
    logic [32:0] m2;
    int sv, ss;
    r = '0;
    if (m) begin
      logic [19:0] best;
      best = win_buy;
      if (win_sell > best) best = win_sell;
      if (win_neutral > best) best = win_neutral;
      if (best == 0) s = SIG_NEUTRAL;
      else if (win_buy == best) s = SIG_BUY;
      else if (win_neutral == best) s = SIG_NEUTRAL;
      else s = SIG_SELL;
    end else begin
      m2 = {2'b0, b} + {2'b0, a};
      sp = longint'(a) - longint'(b);
      tot = 64'(bv) + 64'(av);
      r.wmid2 = m2[31:0];
      if (tot != 0) begin
        num = 64'(bv) * 64'(a) + 64'(av) * 64'(b);
        q = num / tot; rem = num % tot;
        r.wmid2 = 32'(2 * q + ((2 * rem >= tot) ? 1 : 0));
        bvs = 64'(bv) << 16;
        r.share = 17'(bvs / tot);
        sv = (bv > av) ? 1 : (bv < av) ? -1 : 0;
        ss = (sp > 0) ? 1 : (sp < 0) ? -1 : 0;
        if (sv * ss > 0 && bvs > 64'(buy_thr) * tot) s = SIG_BUY;
        else if (sv * ss < 0 && bvs < 64'(sell_thr) * tot) s = SIG_SELL;
        else s = SIG_NEUTRAL;
      end else if (prev_seen) begin
        d2 = longint'(m2) - longint'(prev_mid2);
        scaled = sp * longint'(frac_thr);
        lhs = d2 * 32768;
        mt2 = 2 * longint'(tick_min);
        if (d2 > mt2 && lhs > scaled) s = SIG_BUY;
        else if (-d2 > mt2 && -lhs > scaled) s = SIG_SELL;
        else s = SIG_NEUTRAL;
      end else s = SIG_NEUTRAL;
      prev_mid2 = m2; prev_seen = 1;
      if (win_quotes != CNT_MAX) win_spread_sum += sp;
      win_quotes = sat_inc(win_quotes);
      if (s == SIG_BUY) win_buy = sat_inc(win_buy);
      else if (s == SIG_SELL) win_sell = sat_inc(win_sell);
      else win_neutral = sat_inc(win_neutral);
      win_last_mid = m2;
      r.spr = 32'(sp); r.mid2 = m2[31:0];
    end
    r.sig = s;
    r.nb = win_buy; r.ns = win_sell; r.nn = win_neutral; r.nq = win_quotes;
    r.avg = (win_quotes == 0) ? 32'd0 : 32'(win_spread_sum / longint'(win_quotes));
    r.last = win_last_mid[31:0];
    if (m) begin
      win_buy = 0; win_sell = 0; win_neutral = 0; win_quotes = 0; win_spread_sum = 0;
    end
    return r;
  endfunction

  // Write one threshold register while idle
  task automatic write_threshold(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      CFG_BUY_RATIO:  buy_thr = val[15:0];
      CFG_SELL_RATIO: sell_thr = val[15:0];
      CFG_MIN_TICK:   tick_min = val;
      default:        frac_thr = val[15:0];
    endcase
  endtask

  // Drive one transaction and hold it until accepted
  task automatic send_quote(logic m, logic [30:0] b, logic [30:0] a,
                            logic [31:0] bv, logic [31:0] av);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1; mode <= m; bid <= b; ask <= a; bid_size <= bv; ask_size <= av;
    pending_results.push_back(predict_quote(m, b, a, bv, av));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk); guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  // Receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      quote_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result"); errors++;
      end else begin
        e = pending_results.pop_front();
        if (signal !== e.sig) begin
          $error("signal exp %0d got %0d", e.sig, signal); errors++; end
        if (spread !== e.spr) begin
          $error("spread exp %0d got %0d", $signed(e.spr), spread); errors++; end
        if (mid_doubled !== e.mid2) begin
          $error("mid_doubled exp %0d got %0d", e.mid2, mid_doubled); errors++; end
        if (weighted_mid_doubled !== e.wmid2) begin
          $error("weighted_mid_doubled exp %0d got %0d", e.wmid2, weighted_mid_doubled);
          errors++; end
        if (bid_share !== e.share) begin
          $error("bid_share exp %0d got %0d", e.share, bid_share); errors++; end
        if (buy_total !== e.nb) begin
          $error("buy_total exp %0d got %0d", e.nb, buy_total); errors++; end
        if (sell_total !== e.ns) begin
          $error("sell_total exp %0d got %0d", e.ns, sell_total); errors++; end
        if (neutral_total !== e.nn) begin
          $error("neutral_total exp %0d got %0d", e.nn, neutral_total); errors++; end
        if (quote_total !== e.nq) begin
          $error("quote_total exp %0d got %0d", e.nq, quote_total); errors++; end
        if (average_spread !== e.avg) begin
          $error("average_spread exp %0d got %0d", $signed(e.avg), average_spread);
          errors++; end
        if (last_mid_doubled !== e.last) begin
          $error("last_mid_doubled exp %0d got %0d", e.last, last_mid_doubled); errors++; end
      end
    end
  end

  // Extremes, special cases, closes on ties and empty windows
  task automatic test_directed();
    send_quote(1, 0, 0, 0, 0);
    send_quote(0, 100, 110, 0, 0);
    send_quote(0, 110, 120, 0, 0);
    send_quote(0, 90, 100, 0, 0);
    send_quote(0, 90, 100, 0, 0);
    send_quote(0, 100, 110, 900, 100);
    send_quote(0, 100, 110, 100, 900);
    send_quote(0, 100, 110, 500, 500);
    send_quote(0, 110, 100, 900, 100);
    send_quote(0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_quote(0, 0, 31'h7FFFFFFF, 32'hFFFFFFFF, 0);
    send_quote(0, 31'h7FFFFFFF, 0, 0, 32'hFFFFFFFF);
    send_quote(0, 0, 0, 0, 1);
    send_quote(1, 0, 0, 0, 0);
    send_quote(0, 100, 110, 900, 100);
    send_quote(0, 100, 110, 100, 900);
    send_quote(1, 5, 5, 5, 5);
    send_quote(0, 100, 110, 500, 500);
    send_quote(0, 100, 110, 100, 900);
    send_quote(1, 0, 0, 0, 0);
    send_quote(1, 0, 0, 0, 0);
  endtask

  task automatic test_thresholds();
    write_threshold(CFG_BUY_RATIO, 0);
    write_threshold(CFG_SELL_RATIO, 16'hFFFF);
    write_threshold(CFG_MIN_TICK, 0);
    write_threshold(CFG_TICK_FRAC, 0);
    send_quote(0, 100, 110, 2, 1);
    send_quote(0, 100, 110, 1, 2);
    send_quote(0, 100, 110, 0, 0);
    send_quote(0, 101, 110, 0, 0);
    send_quote(1, 0, 0, 0, 0);
    wait_idle();
    write_threshold(CFG_BUY_RATIO, 16'hFFFF);
    write_threshold(CFG_SELL_RATIO, 0);
    write_threshold(CFG_MIN_TICK, 31'h7FFFFFFF);
    write_threshold(CFG_TICK_FRAC, 16'hFFFF);
    send_quote(0, 100, 110, 32'hFFFFFFFF, 0);
    send_quote(0, 0, 0, 0, 0);
    send_quote(0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0);
    send_quote(1, 0, 0, 0, 0);
    wait_idle();
  endtask

  // Random windows; mostly nearby prices so both tests fire in both directions
  task automatic test_random(int n);
    logic [30:0] base, b, a;
    logic [31:0] bv, av;
    int k;
    base = 31'($urandom_range(1000, 100000));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) begin
        send_quote(1, 31'($urandom), 31'($urandom), $urandom, $urandom);
        continue;
      end
      case ($urandom_range(3))
        0: begin b = 31'($urandom); a = 31'($urandom); end
        default: begin
          base = 31'(base + $urandom_range(40) - 20);
          b = base; a = 31'(base + $urandom_range(30) - 5);
        end
      endcase
      case ($urandom_range(4))
        0, 1: begin bv = 0; av = 0; end
        2: begin bv = $urandom; av = $urandom; end
        default: begin bv = $urandom_range(1000); av = $urandom_range(1000); end
      endcase
      send_quote(0, b, a, bv, av);
    end
    send_quote(1, 0, 0, 0, 0);
    wait_idle();
  endtask

  task automatic set_random_thresholds();
    write_threshold(CFG_BUY_RATIO, 31'($urandom_range(32768, 65535)));
    write_threshold(CFG_SELL_RATIO, 31'($urandom_range(0, 32768)));
    write_threshold(CFG_MIN_TICK, 31'($urandom_range(0, 8)));
    write_threshold(CFG_TICK_FRAC, 31'($urandom));
  endtask

  initial begin
    buy_thr = 39322; sell_thr = 26214; tick_min = 1; frac_thr = 16384;
    prev_mid2 = 0; prev_seen = 0; win_last_mid = 0;
    win_buy = 0; win_sell = 0; win_neutral = 0; win_quotes = 0; win_spread_sum = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_idle_pct = 18; recv_idle_pct = 70;
    test_directed();
    wait_idle();
    test_thresholds();
    test_random(370);
    set_random_thresholds();
    send_idle_pct = 70; recv_idle_pct = 18;
    test_random(370);
    write_threshold(CFG_BUY_RATIO, 39322);
    write_threshold(CFG_SELL_RATIO, 26214);
    write_threshold(CFG_MIN_TICK, 1);
    write_threshold(CFG_TICK_FRAC, 16384);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(370);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold-off against a hung block
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
